// File: sv/i2cas_pkg.sv
// package: widths, event codes and register addresses of the accelerometer register target
package i2cas_pkg;

  localparam int unsigned RegCountDefault = 256;
  localparam int unsigned DevAddrReset    = 25;

  localparam int unsigned AddrW  = 8;
  localparam int unsigned DataW  = 8;
  localparam int unsigned DevW   = 7;
  localparam int unsigned AccelW = 18;
  localparam int unsigned TempW  = 12;

  typedef enum logic [1:0] {
    ModeConnect    = 2'd0,
    ModeWrite      = 2'd1,
    ModeRead       = 2'd2,
    ModeDisconnect = 2'd3
  } mode_e;

  localparam logic [AddrW-1:0] AddrTempOut  = 8'h0E;
  localparam logic [AddrW-1:0] AddrWhoAmI   = 8'h0F;
  localparam logic [AddrW-1:0] AddrCtrl2    = 8'h21;
  localparam logic [AddrW-1:0] AddrCtrl4    = 8'h23;
  localparam logic [AddrW-1:0] AddrCtrl6    = 8'h25;
  localparam logic [AddrW-1:0] AddrTempL    = 8'h26;
  localparam logic [AddrW-1:0] AddrStatus   = 8'h27;
  localparam logic [AddrW-1:0] AddrOutXL    = 8'h28;
  localparam logic [AddrW-1:0] AddrOutXH    = 8'h29;
  localparam logic [AddrW-1:0] AddrOutYL    = 8'h2A;
  localparam logic [AddrW-1:0] AddrOutYH    = 8'h2B;
  localparam logic [AddrW-1:0] AddrOutZL    = 8'h2C;
  localparam logic [AddrW-1:0] AddrOutZH    = 8'h2D;
  localparam logic [AddrW-1:0] AddrStatusDup = 8'h2F;
  localparam logic [AddrW-1:0] AddrStatusB  = 8'h37;
  localparam logic [AddrW-1:0] AddrStatusC  = 8'h3B;

  localparam logic [DataW-1:0] WhoAmIValue = 8'h44;
  localparam logic [DataW-1:0] Ctrl2Reset  = 8'h04;

  localparam int unsigned Ctrl2IncBit   = 2;
  localparam int unsigned Ctrl2ResetBit = 6;
  localparam int unsigned SelIncBit     = 7;

  function automatic logic is_read_only(input logic [AddrW-1:0] addr);
    logic ro;
    ro = 1'b0;
    if (addr inside {AddrWhoAmI, AddrTempL, AddrStatus, [AddrOutXL:AddrOutZH], AddrStatusDup}) begin
      ro = 1'b1;
    end
    return ro;
  endfunction

endpackage

// File: sv/i2cas_if.sv
// interfaces: bus event, result and device address channels

interface i2cas_evt_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           mode;
  logic [i2cas_pkg::DevW-1:0]           bus_address;
  logic                                 is_read;
  logic [i2cas_pkg::DataW-1:0]          write_data;
  logic signed [i2cas_pkg::AccelW-1:0]  accel_x;
  logic signed [i2cas_pkg::AccelW-1:0]  accel_y;
  logic signed [i2cas_pkg::AccelW-1:0]  accel_z;
  logic signed [i2cas_pkg::TempW-1:0]   temperature_q4;
  logic                                 sample_ready;

  modport source (output valid, mode, bus_address, is_read, write_data, accel_x, accel_y,
                  accel_z, temperature_q4, sample_ready, input ready);
  modport sink (input valid, mode, bus_address, is_read, write_data, accel_x, accel_y,
                accel_z, temperature_q4, sample_ready, output ready);
endinterface

interface i2cas_res_if;
  logic                        valid;
  logic                        ready;
  logic [i2cas_pkg::DataW-1:0] read_data;
  logic                        acknowledge;
  logic                        int1_level;

  modport source (output valid, read_data, acknowledge, int1_level, input ready);
  modport sink (input valid, read_data, acknowledge, int1_level, output ready);
endinterface

interface i2cas_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [i2cas_pkg::DevW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: sv/i2c_accelerometer_register_slave_core.sv
// top level: accelerometer register target driven by bus events
//
// Takes one bus event (connect, byte write, byte read, disconnect) per clock cycle and
// returns its result from a result register in the cycle after acceptance. Throughput is one
// event per cycle, set by the single write port and registered read port of the register
// file memory; intake stalls only while a finished result waits to be taken. The register
// file needs no clearing pass: per-entry valid bits restore the reset image at once, after
// reset and after a CTRL2 soft reset. The device address port is always ready.
module i2c_accelerometer_register_slave_core #(
  parameter int unsigned REG_COUNT = i2cas_pkg::RegCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cas_evt_if.sink   evt_i,
  i2cas_res_if.source res_o,
  i2cas_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(REG_COUNT);
  localparam int unsigned AddrW = i2cas_pkg::AddrW;
  localparam int unsigned DataW = i2cas_pkg::DataW;

  logic [DataW-1:0] mem_q [REG_COUNT];
  logic [DataW-1:0] mem_rd_q;
  logic [REG_COUNT-1:0] vld_q, vld_d;

  logic [i2cas_pkg::DevW-1:0] dev_addr_q;
  logic [AddrW-1:0] sel_q, sel_d;
  logic [AddrW-1:0] off_q, off_d;
  logic             busy_q, busy_d;
  logic             inc_q, inc_d;
  logic             int1_q, int1_d;
  logic             ctrl2_inc_q, ctrl2_inc_d;
  logic             ctrl4_int_q, ctrl4_int_d;
  logic [1:0]       ctrl6_fs_q, ctrl6_fs_d;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] rd_q, rd_d;
  logic             sel_mem_q, sel_mem_d;
  logic             ack_q, ack_d;

  logic             accept;
  i2cas_pkg::mode_e mode;
  logic [AddrW-1:0] rd_addr;
  logic             rd_in_range;
  logic             wr_in_range;
  logic             mem_we;
  logic             soft_rst;
  logic [AW-1:0]    rd_idx;
  logic [AW-1:0]    wr_idx;

  logic signed [i2cas_pkg::AccelW-1:0] axis;
  logic                                axis_neg;
  logic [i2cas_pkg::AccelW-1:0]        axis_mag;
  logic [i2cas_pkg::AccelW:0]          axis_sum;
  logic [i2cas_pkg::AccelW:0]          axis_rnd;
  logic [13:0]                         axis_cnt;
  logic [15:0]                         axis_word;
  logic [i2cas_pkg::AccelW:0]          axis_half;

  logic signed [i2cas_pkg::TempW-1:0]  temp_clamp;
  logic signed [i2cas_pkg::TempW:0]    temp_diff;
  logic                                temp_neg;
  logic [10:0]                         temp_mag;
  logic [11:0]                         temp_rnd;
  logic [DataW-1:0]                    temp_byte;

  assign accept      = evt_i.valid && evt_i.ready;
  assign evt_i.ready = !out_valid_q || res_o.ready;
  assign mode        = i2cas_pkg::mode_e'(evt_i.mode);
  assign cfg_i.ready = 1'b1;

  assign rd_addr     = inc_q ? AddrW'(sel_q + off_q) : sel_q;
  assign rd_in_range = ({1'b0, rd_addr} < (AddrW + 1)'(REG_COUNT));
  assign wr_in_range = ({1'b0, sel_q} < (AddrW + 1)'(REG_COUNT));
  assign rd_idx      = rd_addr[AW-1:0];
  assign wr_idx      = sel_q[AW-1:0];

  // axis count: round half away from zero, clamp to 14 bits, left aligned
  always_comb begin
    case (rd_addr)
      i2cas_pkg::AddrOutXL, i2cas_pkg::AddrOutXH: axis = evt_i.accel_x;
      i2cas_pkg::AddrOutYL, i2cas_pkg::AddrOutYH: axis = evt_i.accel_y;
      default:                                    axis = evt_i.accel_z;
    endcase
    axis_neg  = axis[i2cas_pkg::AccelW-1];
    axis_mag  = axis_neg ? i2cas_pkg::AccelW'(-axis) : i2cas_pkg::AccelW'(axis);
    case (ctrl6_fs_q)
      2'd0:    axis_half = '0;
      2'd1:    axis_half = (i2cas_pkg::AccelW + 1)'(1);
      2'd2:    axis_half = (i2cas_pkg::AccelW + 1)'(2);
      default: axis_half = (i2cas_pkg::AccelW + 1)'(4);
    endcase
    axis_sum = {1'b0, axis_mag} + axis_half;
    axis_rnd = axis_sum >> ctrl6_fs_q;
    if (!axis_neg && axis_rnd > (i2cas_pkg::AccelW + 1)'(8191)) begin
      axis_cnt = 14'h1FFF;
    end else if (axis_neg && axis_rnd > (i2cas_pkg::AccelW + 1)'(8192)) begin
      axis_cnt = 14'h2000;
    end else if (axis_neg) begin
      axis_cnt = ~axis_rnd[13:0] + 14'd1;
    end else begin
      axis_cnt = axis_rnd[13:0];
    end
    axis_word = {axis_cnt, 2'b00};
  end

  // temperature byte relative to 25 C
  always_comb begin
    if (evt_i.temperature_q4 < -12'sd640) begin
      temp_clamp = -12'sd640;
    end else if (evt_i.temperature_q4 > 12'sd1360) begin
      temp_clamp = 12'sd1360;
    end else begin
      temp_clamp = evt_i.temperature_q4;
    end
    temp_diff = (i2cas_pkg::TempW + 1)'(temp_clamp) - 13'sd400;
    temp_neg  = temp_diff[i2cas_pkg::TempW];
    temp_mag  = temp_neg ? 11'(-temp_diff) : 11'(temp_diff);
    temp_rnd  = ({1'b0, temp_mag} + 12'd8) >> 4;
    temp_byte = temp_neg ? DataW'(~temp_rnd + 12'd1) : DataW'(temp_rnd);
  end

  always_comb begin
    sel_d       = sel_q;
    off_d       = off_q;
    busy_d      = busy_q;
    inc_d       = inc_q;
    int1_d      = int1_q;
    ctrl2_inc_d = ctrl2_inc_q;
    ctrl4_int_d = ctrl4_int_q;
    ctrl6_fs_d  = ctrl6_fs_q;
    vld_d       = vld_q;
    rd_d        = '0;
    sel_mem_d   = 1'b0;
    ack_d       = 1'b0;
    mem_we      = 1'b0;
    soft_rst    = 1'b0;
    case (mode)
      i2cas_pkg::ModeConnect: begin
        if (!evt_i.is_read) begin
          busy_d = 1'b0;
        end
        off_d = '0;
        ack_d = (evt_i.bus_address == dev_addr_q);
      end
      i2cas_pkg::ModeWrite: begin
        ack_d  = 1'b1;
        busy_d = 1'b1;
        if (!busy_q) begin
          sel_d = {1'b0, evt_i.write_data[AddrW-2:0]};
          inc_d = evt_i.write_data[i2cas_pkg::SelIncBit] || ctrl2_inc_q;
        end else begin
          if (!i2cas_pkg::is_read_only(sel_q)) begin
            if (wr_in_range) begin
              mem_we        = 1'b1;
              vld_d[wr_idx] = 1'b1;
              case (sel_q)
                i2cas_pkg::AddrCtrl2: begin
                  ctrl2_inc_d = evt_i.write_data[i2cas_pkg::Ctrl2IncBit];
                  soft_rst    = evt_i.write_data[i2cas_pkg::Ctrl2ResetBit];
                end
                i2cas_pkg::AddrCtrl4: ctrl4_int_d = evt_i.write_data[0];
                i2cas_pkg::AddrCtrl6: ctrl6_fs_d  = evt_i.write_data[5:4];
                default: ;
              endcase
              if (soft_rst) begin
                vld_d       = '0;
                ctrl2_inc_d = i2cas_pkg::Ctrl2Reset[i2cas_pkg::Ctrl2IncBit];
                ctrl4_int_d = 1'b0;
                ctrl6_fs_d  = '0;
              end
            end
            int1_d = ctrl4_int_d && evt_i.sample_ready;
          end
          if (inc_q) begin
            sel_d = AddrW'(sel_q + 1'b1);
          end
        end
      end
      i2cas_pkg::ModeRead: begin
        off_d  = AddrW'(off_q + 1'b1);
        int1_d = ctrl4_int_q && evt_i.sample_ready;
        case (rd_addr)
          i2cas_pkg::AddrWhoAmI: rd_d = i2cas_pkg::WhoAmIValue;
          i2cas_pkg::AddrTempOut, i2cas_pkg::AddrTempL: rd_d = temp_byte;
          i2cas_pkg::AddrStatus, i2cas_pkg::AddrStatusB, i2cas_pkg::AddrStatusC:
            rd_d = {7'd0, evt_i.sample_ready};
          i2cas_pkg::AddrStatusDup: rd_d = '0;
          i2cas_pkg::AddrOutXL, i2cas_pkg::AddrOutYL, i2cas_pkg::AddrOutZL:
            rd_d = axis_word[7:0];
          i2cas_pkg::AddrOutXH, i2cas_pkg::AddrOutYH, i2cas_pkg::AddrOutZH:
            rd_d = axis_word[15:8];
          default: begin
            if (rd_in_range && vld_q[rd_idx]) begin
              sel_mem_d = 1'b1;
            end else if (rd_in_range && rd_addr == i2cas_pkg::AddrCtrl2) begin
              rd_d = i2cas_pkg::Ctrl2Reset;
            end
          end
        endcase
      end
      default: begin
        busy_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= i2cas_pkg::DevW'(i2cas_pkg::DevAddrReset);
      sel_q       <= '0;
      off_q       <= '0;
      busy_q      <= 1'b0;
      inc_q       <= 1'b0;
      int1_q      <= 1'b0;
      ctrl2_inc_q <= i2cas_pkg::Ctrl2Reset[i2cas_pkg::Ctrl2IncBit];
      ctrl4_int_q <= 1'b0;
      ctrl6_fs_q  <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      sel_mem_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        dev_addr_q <= cfg_i.data;
      end
      if (accept) begin
        sel_q       <= sel_d;
        off_q       <= off_d;
        busy_q      <= busy_d;
        inc_q       <= inc_d;
        int1_q      <= int1_d;
        ctrl2_inc_q <= ctrl2_inc_d;
        ctrl4_int_q <= ctrl4_int_d;
        ctrl6_fs_q  <= ctrl6_fs_d;
        vld_q       <= vld_d;
        sel_mem_q   <= sel_mem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q  <= rd_d;
      ack_q <= ack_d;
    end
  end

  // register file: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      mem_q[wr_idx] <= evt_i.write_data;
    end
    if (accept && mode == i2cas_pkg::ModeRead) begin
      mem_rd_q <= mem_q[rd_idx];
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.read_data   = sel_mem_q ? mem_rd_q : rd_q;
  assign res_o.acknowledge = ack_q;
  assign res_o.int1_level  = int1_q;

  a_res_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(evt_i.valid && evt_i.ready))
    else $error("result appeared without an accepted transaction");

  a_connect_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode == i2cas_pkg::ModeConnect || mode == i2cas_pkg::ModeDisconnect)
      |=> res_o.read_data == '0)
    else $error("connect or disconnect returned read data");

  a_read_no_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode == i2cas_pkg::ModeRead || mode == i2cas_pkg::ModeDisconnect)
      |=> !res_o.acknowledge)
    else $error("read or disconnect acknowledged");

  a_soft_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && soft_rst |=> vld_q == '0 && ctrl2_inc_q && !ctrl4_int_q && ctrl6_fs_q == '0)
    else $error("soft reset left register state behind");

endmodule
